// File: rtl/mwpo_pkg.sv
// shared constants, types and sine table for the multiwave phase oscillator
package mwpo_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int QUARTER_LEN     = 1 << QUARTER_BITS;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 49;

  localparam int MUL_OP_W  = 33;
  localparam int MUL_OUT_W = 2 * MUL_OP_W;
  localparam int ACC_W     = 42;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHAPE_SEL         = 4'd0,
    REG_DEFAULT_FREQUENCY = 4'd1,
    REG_FREQ_MULTIPLIER   = 4'd2,
    REG_DETUNE_OFFSET     = 4'd3,
    REG_OUTPUT_VOLUME     = 4'd4,
    REG_MOD_GAIN          = 4'd5,
    REG_PULSE_DUTY        = 4'd6,
    REG_STEP_SCALE        = 4'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SHAPE_SINE     = 3'd0,
    SHAPE_SQUARE   = 3'd1,
    SHAPE_SAW      = 3'd2,
    SHAPE_TRIANGLE = 3'd3,
    SHAPE_RAMP     = 3'd4,
    SHAPE_PULSE    = 3'd5
  } shape_t;

  localparam logic [2:0]         SHAPE_SEL_RESET    = 3'd0;
  localparam logic signed [31:0] DEFAULT_FREQ_RESET = 32'sd28835840;
  localparam logic signed [23:0] FREQ_MULT_RESET    = 24'sd65536;
  localparam logic signed [31:0] DETUNE_RESET       = 32'sd0;
  localparam logic signed [15:0] VOLUME_RESET       = 16'sd16384;
  localparam logic signed [23:0] MOD_GAIN_RESET     = 24'sd0;
  localparam logic [16:0]        PULSE_DUTY_RESET   = 17'd32768;
  localparam logic [48:0]        STEP_SCALE_RESET   = 49'd5864062014;

  localparam longint SIN_C1  = 64'sd1686629713;
  localparam longint SIN_C3  = 64'sd693598668;
  localparam longint SIN_C5  = 64'sd85569306;
  localparam longint SIN_C7  = 64'sd5026995;
  localparam longint SIN_C9  = 64'sd172272;
  localparam longint SIN_C11 = 64'sd3864;

  typedef logic [15:0] sine_quarter_t [QUARTER_LEN];

  // sin(pi/2 * t), t in q2.30, result in q15
  function automatic longint quarter_sine(longint t);
    longint t2;
    longint acc;
    longint s;
    t2  = (t * t) >>> 30;
    acc = SIN_C11;
    acc = SIN_C9 - ((acc * t2) >>> 30);
    acc = SIN_C7 - ((acc * t2) >>> 30);
    acc = SIN_C5 - ((acc * t2) >>> 30);
    acc = SIN_C3 - ((acc * t2) >>> 30);
    acc = SIN_C1 - ((acc * t2) >>> 30);
    if (acc < 0) begin
      acc = 0;
    end
    s = (acc * t) >>> 30;
    s = (s + 64'sd16384) >>> 15;
    if (s > 64'sd32768) begin
      s = 64'sd32768;
    end
    return s;
  endfunction

  function automatic sine_quarter_t build_sine_quarter();
    sine_quarter_t tbl;
    for (int j = 0; j < QUARTER_LEN; j++) begin
      tbl[j] = 16'(quarter_sine(longint'(j) <<< (32 - SINE_TABLE_BITS)));
    end
    return tbl;
  endfunction

  localparam sine_quarter_t SINE_QUARTER = build_sine_quarter();
  localparam logic [15:0]   SINE_PEAK    = 16'(quarter_sine(longint'(1) <<< 30));

endpackage

// File: rtl/mwpo_ifs.sv
// valid/ready channel interfaces for item, result and configuration transfers
interface mwpo_item_if;
  logic               valid;
  logic               ready;
  logic               has_base_hz;
  logic signed [31:0] base_hz;
  logic signed [31:0] modulation_sample;

  modport source (output valid, has_base_hz, base_hz, modulation_sample,
                  input ready);
  modport sink (input valid, has_base_hz, base_hz, modulation_sample,
                output ready);
endinterface

interface mwpo_result_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

interface mwpo_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mwpo_pkg::CFG_INDEX_W-1:0]    index;
  logic [mwpo_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/multiwave_phase_oscillator_core.sv
// multiwave phase oscillator: phase accumulator with fm and six waveforms
// Each input item gives one output sample. The block takes no new item until the last has
// passed through all its states: one shared 33x33 signed multiplier is used in turn for
// volume times wave, base times multiplier, modulation times gain and the two halves of
// frequency times step scale, with ST_SUM for the sum and clamp and ST_ADV for the phase
// advance. The sample sits in an output register, so the next item can be taken while it
// waits; the phase advance holds only while that register is still full. Configuration
// writes are always taken and must only be made while no item is in flight.
module multiwave_phase_oscillator_core (
  input  logic                  clk,
  input  logic                  rst,
  mwpo_cfg_if.sink              cfg,
  mwpo_item_if.sink             item,
  mwpo_result_if.source         result
);

  localparam int PB  = mwpo_pkg::PHASE_BITS;
  localparam int STB = mwpo_pkg::SINE_TABLE_BITS;
  localparam int QB  = mwpo_pkg::QUARTER_BITS;
  localparam int MW  = mwpo_pkg::MUL_OP_W;
  localparam int PW  = mwpo_pkg::MUL_OUT_W;
  localparam int AW  = mwpo_pkg::ACC_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_WAVE = 8'b0000_0010,
    ST_FM   = 8'b0000_0100,
    ST_MM   = 8'b0000_1000,
    ST_SUM  = 8'b0001_0000,
    ST_LO   = 8'b0010_0000,
    ST_HI   = 8'b0100_0000,
    ST_ADV  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [2:0]         shape_sel;
  logic signed [31:0] default_frequency;
  logic signed [23:0] frequency_multiplier;
  logic signed [31:0] detune_offset;
  logic signed [15:0] output_volume;
  logic signed [23:0] mod_gain;
  logic [16:0]        pulse_duty;
  logic [48:0]        step_scale;

  logic [PB-1:0]      phase;
  logic signed [31:0] base;
  logic signed [31:0] modv;
  logic signed [16:0] wave;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic [31:0]        freq;
  logic [63:0]        step_lo;
  logic [17:0]        sample;
  logic               out_valid;
  logic [17:0]        out_sample;

  logic               accept;
  logic               out_free;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_sel            <= mwpo_pkg::SHAPE_SEL_RESET;
      default_frequency    <= mwpo_pkg::DEFAULT_FREQ_RESET;
      frequency_multiplier <= mwpo_pkg::FREQ_MULT_RESET;
      detune_offset        <= mwpo_pkg::DETUNE_RESET;
      output_volume        <= mwpo_pkg::VOLUME_RESET;
      mod_gain             <= mwpo_pkg::MOD_GAIN_RESET;
      pulse_duty           <= mwpo_pkg::PULSE_DUTY_RESET;
      step_scale           <= mwpo_pkg::STEP_SCALE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        mwpo_pkg::REG_SHAPE_SEL:         shape_sel            <= cfg.data[2:0];
        mwpo_pkg::REG_DEFAULT_FREQUENCY: default_frequency    <= cfg.data[31:0];
        mwpo_pkg::REG_FREQ_MULTIPLIER:   frequency_multiplier <= cfg.data[23:0];
        mwpo_pkg::REG_DETUNE_OFFSET:     detune_offset        <= cfg.data[31:0];
        mwpo_pkg::REG_OUTPUT_VOLUME:     output_volume        <= cfg.data[15:0];
        mwpo_pkg::REG_MOD_GAIN:          mod_gain             <= cfg.data[23:0];
        mwpo_pkg::REG_PULSE_DUTY:        pulse_duty           <= cfg.data[16:0];
        mwpo_pkg::REG_STEP_SCALE:        step_scale           <= cfg.data[48:0];
        default: ;
      endcase
    end
  end

  // waveform at the current phase
  logic [PB+31:0]     phase_ext;
  logic [31:0]        p32;
  logic [STB-1:0]     k;
  logic [1:0]         quad;
  logic [QB-1:0]      r;
  logic [QB:0]        j;
  logic [15:0]        mag;
  logic [31:0]        tri_dist;
  logic signed [17:0] ramp_up;
  logic signed [17:0] tri_val;
  logic signed [16:0] wave_comb;

  always_comb begin
    phase_ext = {phase, 32'b0};
    p32       = phase_ext[PB+31 -: 32];
    k         = p32[31 -: STB];
    quad      = k[STB-1 -: 2];
    r         = k[QB-1:0];
    j         = quad[0] ? ((QB+1)'(mwpo_pkg::QUARTER_LEN) - {1'b0, r}) : {1'b0, r};
    mag       = j[QB] ? mwpo_pkg::SINE_PEAK : mwpo_pkg::SINE_QUARTER[j[QB-1:0]];
    tri_dist  = p32[31] ? (p32 - 32'h8000_0000) : (32'h8000_0000 - p32);
    ramp_up   = $signed({2'b00, p32[31:16]}) - 18'sd32768;
    tri_val   = $signed({1'b0, tri_dist[31:15]}) - 18'sd32768;
    case (shape_sel)
      mwpo_pkg::SHAPE_SINE:
        wave_comb = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      mwpo_pkg::SHAPE_SQUARE:
        wave_comb = (!p32[31] && (p32 != 32'd0)) ? 17'sd32768 : -17'sd32768;
      mwpo_pkg::SHAPE_SAW:
        wave_comb = ramp_up[16:0];
      mwpo_pkg::SHAPE_TRIANGLE:
        wave_comb = tri_val[16:0];
      mwpo_pkg::SHAPE_RAMP:
        wave_comb = 17'(-ramp_up);
      mwpo_pkg::SHAPE_PULSE:
        wave_comb = ({1'b0, p32} < {pulse_duty, 16'b0}) ? 17'sd32768 : -17'sd32768;
      default:
        wave_comb = 17'sd0;
    endcase
  end

  // shared multiplier operand select
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_WAVE: begin
        mul_a = MW'(output_volume);
        mul_b = MW'(wave);
      end
      ST_FM: begin
        mul_a = MW'(base);
        mul_b = MW'(frequency_multiplier);
      end
      ST_MM: begin
        mul_a = MW'(modv);
        mul_b = MW'(mod_gain);
      end
      ST_LO: begin
        mul_a = $signed({1'b0, freq});
        mul_b = $signed({1'b0, step_scale[31:0]});
      end
      // upper half held while the advance waits on the output register
      ST_HI, ST_ADV: begin
        mul_a = $signed({1'b0, freq});
        mul_b = $signed(MW'(step_scale[48:32]));
      end
      default: ;
    endcase
  end

  // frequency sum and clamp
  logic signed [AW-1:0] prod_hz;
  logic signed [AW-1:0] freq_sum;
  logic [31:0]          freq_next;
  logic [63:0]          step_sum;

  always_comb begin
    prod_hz  = AW'($signed(prod[55:16]));
    freq_sum = acc + prod_hz;
    if (freq_sum[AW-1]) begin
      freq_next = 32'd0;
    end else if (freq_sum[AW-2:32] != '0) begin
      freq_next = 32'hFFFF_FFFF;
    end else begin
      freq_next = freq_sum[31:0];
    end
    step_sum = step_lo + {prod[31:0], 32'b0};
  end

  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item.valid) state_next = ST_WAVE;
      ST_WAVE: state_next = ST_FM;
      ST_FM:   state_next = ST_MM;
      ST_MM:   state_next = ST_SUM;
      ST_SUM:  state_next = ST_LO;
      ST_LO:   state_next = ST_HI;
      ST_HI:   state_next = ST_ADV;
      ST_ADV:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ADV && out_free) begin
        phase     <= phase + step_sum[63 -: PB];
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
    if (accept) begin
      base <= item.has_base_hz ? item.base_hz : default_frequency;
      modv <= item.modulation_sample;
      wave <= wave_comb;
    end
    if (state == ST_FM) begin
      sample <= prod[31:14];
    end
    if (state == ST_MM) begin
      acc <= prod_hz + AW'(detune_offset);
    end
    if (state == ST_SUM) begin
      freq <= freq_next;
    end
    if (state == ST_HI) begin
      step_lo <= prod[63:0];
    end
    if (state == ST_ADV && out_free) begin
      out_sample <= sample;
    end
  end

  assign item.ready        = (state == ST_IDLE);
  assign result.valid      = out_valid;
  assign result.sample_out = out_sample;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_WAVE)
    else $error("item transfer did not start the sequence");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    state != ST_ADV |=> $stable(phase))
    else $error("phase changed outside the advance step");

  a_valid_from_adv: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_ADV))
    else $error("result appeared without an advance step");

  a_adv_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV && out_valid && !result.ready) |=> state == ST_ADV)
    else $error("left advance step while output register was full");

endmodule

// File: tb/sv/multiwave_phase_oscillator_core_tb.sv
// self-checking testbench for the multiwave phase oscillator core
`timescale 1ns / 1ps

module multiwave_phase_oscillator_core_tb;

  localparam longint HORNER_K11 = 64'sd3864;
  localparam longint HORNER_K9  = 64'sd172272;
  localparam longint HORNER_K7  = 64'sd5026995;
  localparam longint HORNER_K5  = 64'sd85569306;
  localparam longint HORNER_K3  = 64'sd693598668;
  localparam longint HORNER_K1  = 64'sd1686629713;
  localparam int     TICKS_PER_PHASE = 115;
  localparam int     RANDOM_PHASES   = 16;
  localparam int     DRAIN_CYCLES    = 16;

  typedef struct {
    logic               has_base;
    logic signed [31:0] base;
    logic signed [31:0] modn;
  } tick_t;

  typedef struct {
    logic [mwpo_pkg::CFG_INDEX_W-1:0] idx;
    logic [mwpo_pkg::CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst;

  mwpo_item_if   item_if();
  mwpo_result_if res_if();
  mwpo_cfg_if    cfg_if();

  multiwave_phase_oscillator_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .item   (item_if),
    .result (res_if)
  );

  always #2 clk = ~clk;

  tick_t                   queued_ticks[$];
  logic signed [17:0]      pending_samples[$];
  reg_write_t              reg_writes[$];
  tick_t                   drive_tick;
  logic signed [17:0]      want_sample;
  int                      idle_pct;
  int                      stall_pct;
  int                      error_count;

  // oscillator state as seen by the checker
  logic [2:0]              osc_shape;
  logic signed [31:0]      osc_def_freq;
  logic signed [23:0]      osc_mult;
  logic signed [31:0]      osc_detune;
  logic signed [15:0]      osc_volume;
  logic signed [23:0]      osc_gain;
  logic [16:0]             osc_duty;
  logic [48:0]             osc_step;
  logic [31:0]             osc_phase;

  // sin(pi/2 * t) with t in q2.30, q15 result
  function automatic longint quarter_wave_q15(longint t);
    longint t2;
    longint acc;
    longint s;
    t2  = (t * t) >>> 30;
    acc = HORNER_K11;
    acc = HORNER_K9 - ((acc * t2) >>> 30);
    acc = HORNER_K7 - ((acc * t2) >>> 30);
    acc = HORNER_K5 - ((acc * t2) >>> 30);
    acc = HORNER_K3 - ((acc * t2) >>> 30);
    acc = HORNER_K1 - ((acc * t2) >>> 30);
    if (acc < 0) begin
      acc = 0;
    end
    s = (acc * t) >>> 30;
    s = (s + 64'sd16384) >>> 15;
    if (s > 64'sd32768) begin
      s = 64'sd32768;
    end
    return s;
  endfunction

  function automatic longint sine_at(logic [31:0] p);
    longint k;
    longint quad;
    longint t;
    longint v;
    k    = longint'(p >> (32 - mwpo_pkg::SINE_TABLE_BITS));
    quad = (k >> (mwpo_pkg::SINE_TABLE_BITS - 2)) & 3;
    t    = (k & ((64'sd1 <<< (mwpo_pkg::SINE_TABLE_BITS - 2)) - 1))
           <<< (32 - mwpo_pkg::SINE_TABLE_BITS);
    if (quad[0]) begin
      t = (64'sd1 <<< 30) - t;
    end
    v = quarter_wave_q15(t);
    return quad[1] ? -v : v;
  endfunction

  // output sample for one tick, then the phase advance
  function automatic logic signed [17:0] next_sample(tick_t tk);
    logic signed [31:0] base;
    longint             fm;
    longint             mm;
    longint             f;
    longint             wave;
    longint             y;
    logic [31:0]        p;
    logic [31:0]        d;
    logic [16:0]        duty;
    logic [63:0]        step_prod;
    base = tk.has_base ? tk.base : osc_def_freq;
    fm   = (longint'(base) * longint'(osc_mult)) >>> 16;
    mm   = (longint'(tk.modn) * longint'(osc_gain)) >>> 16;
    f    = fm + longint'(osc_detune) + mm;
    if (f < 0) begin
      f = 0;
    end else if (f > 64'sh0_FFFF_FFFF) begin
      f = 64'sh0_FFFF_FFFF;
    end
    p = osc_phase;
    case (osc_shape)
      mwpo_pkg::SHAPE_SINE:     wave = sine_at(p);
      mwpo_pkg::SHAPE_SQUARE:   wave = (p != 32'd0 && p < 32'h8000_0000) ? 32768 : -32768;
      mwpo_pkg::SHAPE_SAW:      wave = longint'(p[31:16]) - 32768;
      mwpo_pkg::SHAPE_TRIANGLE: begin
        d    = p[31] ? p - 32'h8000_0000 : 32'h8000_0000 - p;
        wave = longint'(d >> 15) - 32768;
      end
      mwpo_pkg::SHAPE_RAMP:     wave = 32768 - longint'(p[31:16]);
      mwpo_pkg::SHAPE_PULSE: begin
        duty = (osc_duty > 17'd65536) ? 17'd65536 : osc_duty;
        wave = (64'(p) < (64'(duty) << 16)) ? 32768 : -32768;
      end
      default:                  wave = 0;
    endcase
    y         = (longint'(osc_volume) * wave) >>> 14;
    step_prod = 64'(f) * 64'(osc_step);
    osc_phase = osc_phase + step_prod[63:32];
    return y[17:0];
  endfunction

  function automatic logic [mwpo_pkg::CFG_DATA_W-1:0] reg_value(int w, int pat);
    case (pat)
      0:       return '0;
      1:       return '1;
      2:       return 49'd1 << (w - 1);
      3:       return (49'd1 << (w - 1)) - 49'd1;
      default: return 49'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return $urandom;
      default: return $urandom_range(0, 32'h03FF_FFFF);
    endcase
  endfunction

  task automatic settle();
    @(negedge clk);
    while (queued_ticks.size() != 0 || item_if.valid || pending_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_writes();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_if.valid <= 1'b1;
      cfg_if.index <= w.idx;
      cfg_if.data  <= w.data;
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else if (!item_if.valid || item_if.ready) begin
      if (queued_ticks.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drive_tick = queued_ticks.pop_front();
        item_if.valid             <= 1'b1;
        item_if.has_base_hz       <= drive_tick.has_base;
        item_if.base_hz           <= drive_tick.base;
        item_if.modulation_sample <= drive_tick.modn;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: register writes, accepted ticks and sample checks
  always @(posedge clk) begin
    if (rst) begin
      osc_shape    = mwpo_pkg::SHAPE_SEL_RESET;
      osc_def_freq = mwpo_pkg::DEFAULT_FREQ_RESET;
      osc_mult     = mwpo_pkg::FREQ_MULT_RESET;
      osc_detune   = mwpo_pkg::DETUNE_RESET;
      osc_volume   = mwpo_pkg::VOLUME_RESET;
      osc_gain     = mwpo_pkg::MOD_GAIN_RESET;
      osc_duty     = mwpo_pkg::PULSE_DUTY_RESET;
      osc_step     = mwpo_pkg::STEP_SCALE_RESET;
      osc_phase    = '0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %0d", $time,
                   res_if.sample_out);
          error_count++;
        end else begin
          want_sample = pending_samples.pop_front();
          if (res_if.sample_out !== want_sample) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                     want_sample, res_if.sample_out);
            error_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (mwpo_pkg::cfg_reg_t'(cfg_if.index))
          mwpo_pkg::REG_SHAPE_SEL:         osc_shape    = cfg_if.data[2:0];
          mwpo_pkg::REG_DEFAULT_FREQUENCY: osc_def_freq = cfg_if.data[31:0];
          mwpo_pkg::REG_FREQ_MULTIPLIER:   osc_mult     = cfg_if.data[23:0];
          mwpo_pkg::REG_DETUNE_OFFSET:     osc_detune   = cfg_if.data[31:0];
          mwpo_pkg::REG_OUTPUT_VOLUME:     osc_volume   = cfg_if.data[15:0];
          mwpo_pkg::REG_MOD_GAIN:          osc_gain     = cfg_if.data[23:0];
          mwpo_pkg::REG_PULSE_DUTY:        osc_duty     = cfg_if.data[16:0];
          mwpo_pkg::REG_STEP_SCALE:        osc_step     = cfg_if.data[48:0];
          default: ;
        endcase
      end
      if (item_if.valid && item_if.ready) begin
        pending_samples.push_back(next_sample('{item_if.has_base_hz,
                                                item_if.base_hz,
                                                item_if.modulation_sample}));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[multiwave_phase_oscillator_core] ERROR");
    $finish;
  end

  initial begin
    int pat;
    int w;
    reg_write_t rw;
    tick_t tk;
    rst                       = 1'b1;
    item_if.valid             = 1'b0;
    item_if.has_base_hz       = 1'b0;
    item_if.base_hz           = '0;
    item_if.modulation_sample = '0;
    res_if.ready              = 1'b0;
    cfg_if.valid              = 1'b0;
    cfg_if.index              = '0;
    cfg_if.data               = '0;
    idle_pct                  = 0;
    stall_pct                 = 0;
    error_count               = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: default frequency, clamping of negative base, extreme fields
    @(negedge clk);
    queued_ticks.push_back('{1'b0, 32'sh0, 32'sh0});
    queued_ticks.push_back('{1'b1, 32'sh7FFF_FFFF, 32'sh0});
    queued_ticks.push_back('{1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF});
    queued_ticks.push_back('{1'b1, -32'sd1, 32'sh8000_0000});
    queued_ticks.push_back('{1'b0, 32'sh7FFF_FFFF, -32'sd1});
    settle();

    // every shape, with fm on and a large multiplier to reach saturation
    reg_writes.push_back('{mwpo_pkg::REG_FREQ_MULTIPLIER, 49'd262144});
    reg_writes.push_back('{mwpo_pkg::REG_MOD_GAIN, 49'd65536});
    for (int s = 0; s < 8; s++) begin
      reg_writes.push_back('{mwpo_pkg::REG_SHAPE_SEL, 49'(s)});
      apply_writes();
      @(negedge clk);
      queued_ticks.push_back('{1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
      queued_ticks.push_back('{1'b1, signed'(rand_field()), signed'(rand_field())});
      settle();
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = mwpo_pkg::REG_SHAPE_SEL; i <= mwpo_pkg::REG_STEP_SCALE; i++) begin
        case (mwpo_pkg::cfg_reg_t'(i))
          mwpo_pkg::REG_SHAPE_SEL:       w = 3;
          mwpo_pkg::REG_FREQ_MULTIPLIER,
          mwpo_pkg::REG_MOD_GAIN:        w = 24;
          mwpo_pkg::REG_OUTPUT_VOLUME:   w = 16;
          mwpo_pkg::REG_PULSE_DUTY:      w = 17;
          mwpo_pkg::REG_STEP_SCALE:      w = 49;
          default:                       w = 32;
        endcase
        pat = (p < 4) ? p : $urandom_range(0, 9);
        rw.idx  = mwpo_pkg::CFG_INDEX_W'(i);
        rw.data = reg_value(w, pat);
        if (mwpo_pkg::cfg_reg_t'(i) == mwpo_pkg::REG_SHAPE_SEL) begin
          rw.data = {46'($urandom), 3'(p)};
        end
        reg_writes.push_back(rw);
      end
      // out-of-range index must be ignored
      reg_writes.push_back('{mwpo_pkg::CFG_INDEX_W'($urandom_range(
                               mwpo_pkg::REG_STEP_SCALE + 1, 15)),
                             49'({$urandom, $urandom})});
      apply_writes();
      @(negedge clk);
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 58; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        tk.has_base = 1'($urandom_range(0, 1));
        tk.base     = rand_field();
        tk.modn     = rand_field();
        queued_ticks.push_back(tk);
      end
      settle();
    end

    if (error_count == 0 && pending_samples.size() == 0) begin
      $display("[multiwave_phase_oscillator_core] OK");
    end else begin
      $display("[multiwave_phase_oscillator_core] ERROR");
    end
    $finish;
  end

endmodule
